// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HFCS_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hfcs assertion failed");

// next-cycle implication
`define HFCS_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hfcs assertion failed");

`endif

// ===== rtl/hfcs_pkg.sv =====
// constants and types for the column select block
package hfcs_pkg;
  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 6;
  localparam int CNT_W    = 7;
  localparam int RANK_W   = 3;
  localparam int REL_W    = 16;
  localparam int KEY_W    = REL_W + COL_W;
  localparam int ADDR_W   = 3;

  localparam logic [REL_W-1:0]  SIGN_FLIP = 16'h8000;
  localparam logic [RANK_W-1:0] RANK_MAX  = 3'd7;
  localparam logic [5:0]        ROWS_FULL = 6'd32;
  localparam logic              REG_ROWS  = 1'b0;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SEL     = 8'b0000_0010,
    S_SEL_END = 8'b0000_0100,
    S_ROW     = 8'b0000_1000,
    S_CHASE   = 8'b0001_0000,
    S_COMMIT  = 8'b0010_0000,
    S_NEXT    = 8'b0100_0000,
    S_FLUSH   = 8'b1000_0000
  } state_t;
endpackage

// ===== rtl/hypergraph_forest_column_select_top.sv =====
// column select top: column store, ordering scan and union-find sequencer
// Columns load at one per cycle while busy is low; the item with in_last_column
// starts a run and busy stays high until its last result. For each column in
// order the ordering scan makes one full pass over the store, one store read
// per cycle. Each column then walks its active rows in turn, and for every set
// row follows parent links up to the root; a column whose rows share a root
// is skipped. An accepted column is then committed, and a flush state ends the
// run. Results come one pulse at a time on out_strobe and cannot be held off;
// the final result of a run carries out_last_pick.
`include "assert_macros.svh"

module hypergraph_forest_column_select_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [31:0]                           in_column_rows,
  input  logic signed [hfcs_pkg::REL_W-1:0]     in_reliability,
  input  logic                                  in_last_column,
  output logic                                  out_strobe,
  output logic [hfcs_pkg::COL_W-1:0]            out_column_index,
  output logic                                  out_has_pick,
  output logic                                  out_last_pick,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [hfcs_pkg::ADDR_W-1:0]           cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);

  hfcs_pkg::state_t state_r, state_nxt;

  logic [31:0]                  col_mem [hfcs_pkg::MAX_COLS];
  logic [hfcs_pkg::REL_W-1:0]   rel_mem [hfcs_pkg::MAX_COLS];

  logic [5:0]                   rows_r, rows_nxt;
  logic [hfcs_pkg::CNT_W-1:0]   loaded_r, loaded_nxt;
  logic [hfcs_pkg::CNT_W-1:0]   scan_r, scan_nxt;
  logic [hfcs_pkg::CNT_W-1:0]   picks_r, picks_nxt;
  logic                         cmp_vld_r;
  logic [hfcs_pkg::COL_W-1:0]   cmp_idx_r;
  logic [hfcs_pkg::REL_W-1:0]   cmp_rel_r;
  logic [31:0]                  cmp_bits_r;
  logic                         best_vld_r, best_vld_nxt;
  logic [hfcs_pkg::KEY_W-1:0]   best_key_r, best_key_nxt;
  logic [31:0]                  best_bits_r, best_bits_nxt;
  logic                         prev_vld_r, prev_vld_nxt;
  logic [hfcs_pkg::KEY_W-1:0]   prev_key_r, prev_key_nxt;
  logic [5:0]                   row_r, row_nxt;
  logic [hfcs_pkg::ROW_W-1:0]   node_r, node_nxt;
  logic [hfcs_pkg::MAX_ROWS-1:0] seen_r, seen_nxt;
  logic                         hb_r, hb_nxt;
  logic [hfcs_pkg::RANK_W-1:0]  brank_r, brank_nxt;
  logic [hfcs_pkg::ROW_W-1:0]   broot_r, broot_nxt;
  logic                         tie_r, tie_nxt;
  logic [hfcs_pkg::ROW_W-1:0]   parent_r [hfcs_pkg::MAX_ROWS];
  logic [hfcs_pkg::ROW_W-1:0]   parent_nxt [hfcs_pkg::MAX_ROWS];
  logic [hfcs_pkg::RANK_W-1:0]  rank_r [hfcs_pkg::MAX_ROWS];
  logic [hfcs_pkg::RANK_W-1:0]  rank_nxt [hfcs_pkg::MAX_ROWS];
  logic                         pend_vld_r, pend_vld_nxt;
  logic [hfcs_pkg::COL_W-1:0]   pend_r, pend_nxt;
  logic                         ostb_r, ostb_nxt;
  logic [hfcs_pkg::COL_W-1:0]   oidx_r, oidx_nxt;
  logic                         ohas_r, ohas_nxt;
  logic                         olast_r, olast_nxt;

  logic                         load;
  logic                         cfg_wr;
  logic [5:0]                   rows_eff;
  logic [hfcs_pkg::KEY_W-1:0]   cand_key;
  logic [hfcs_pkg::ROW_W-1:0]   par;
  logic [hfcs_pkg::RANK_W-1:0]  rk;

  assign busy       = (state_r != hfcs_pkg::S_IDLE);
  assign load       = start && !busy;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == hfcs_pkg::REG_ROWS) ? {26'd0, rows_r} : 32'd0;

  assign out_strobe       = ostb_r;
  assign out_column_index = oidx_r;
  assign out_has_pick     = ohas_r;
  assign out_last_pick    = olast_r;

  // clamp rows to 1..32
  always_comb begin
    if (rows_r == 6'd0) begin
      rows_eff = 6'd1;
    end else if (rows_r > hfcs_pkg::ROWS_FULL) begin
      rows_eff = hfcs_pkg::ROWS_FULL;
    end else begin
      rows_eff = rows_r;
    end
  end

  assign cand_key = {cmp_rel_r ^ hfcs_pkg::SIGN_FLIP, cmp_idx_r};
  assign par      = parent_r[node_r];
  assign rk       = rank_r[node_r];

  always_comb begin
    state_nxt     = state_r;
    rows_nxt      = rows_r;
    loaded_nxt    = loaded_r;
    scan_nxt      = scan_r;
    picks_nxt     = picks_r;
    best_vld_nxt  = best_vld_r;
    best_key_nxt  = best_key_r;
    best_bits_nxt = best_bits_r;
    prev_vld_nxt  = prev_vld_r;
    prev_key_nxt  = prev_key_r;
    row_nxt       = row_r;
    node_nxt      = node_r;
    seen_nxt      = seen_r;
    hb_nxt        = hb_r;
    brank_nxt     = brank_r;
    broot_nxt     = broot_r;
    tie_nxt       = tie_r;
    parent_nxt    = parent_r;
    rank_nxt      = rank_r;
    pend_vld_nxt  = pend_vld_r;
    pend_nxt      = pend_r;
    ostb_nxt      = 1'b0;
    oidx_nxt      = oidx_r;
    ohas_nxt      = ohas_r;
    olast_nxt     = olast_r;

    if (cfg_wr && cfg_paddr[2] == hfcs_pkg::REG_ROWS) begin
      rows_nxt = cfg_pwdata[5:0];
    end

    // running minimum over keys above the previous pick
    if (cmp_vld_r && (!prev_vld_r || cand_key > prev_key_r) &&
        (!best_vld_r || cand_key < best_key_r)) begin
      best_vld_nxt  = 1'b1;
      best_key_nxt  = cand_key;
      best_bits_nxt = cmp_bits_r;
    end

    case (state_r)
      hfcs_pkg::S_IDLE: begin
        if (load) begin
          if (loaded_r < hfcs_pkg::CNT_W'(hfcs_pkg::MAX_COLS)) begin
            loaded_nxt = loaded_r + 1'b1;
          end
          if (in_last_column) begin
            state_nxt    = hfcs_pkg::S_SEL;
            scan_nxt     = '0;
            picks_nxt    = '0;
            best_vld_nxt = 1'b0;
            prev_vld_nxt = 1'b0;
            pend_vld_nxt = 1'b0;
          end
        end
      end
      hfcs_pkg::S_SEL: begin
        scan_nxt = scan_r + 1'b1;
        if (scan_r == loaded_r - 1'b1) begin
          state_nxt = hfcs_pkg::S_SEL_END;
        end
      end
      hfcs_pkg::S_SEL_END: begin
        state_nxt = hfcs_pkg::S_ROW;
        row_nxt   = '0;
        seen_nxt  = '0;
        hb_nxt    = 1'b0;
        brank_nxt = '0;
        broot_nxt = '0;
        tie_nxt   = 1'b0;
      end
      hfcs_pkg::S_ROW: begin
        if (row_r == rows_eff) begin
          state_nxt = hfcs_pkg::S_COMMIT;
        end else if (best_bits_r[row_r[hfcs_pkg::ROW_W-1:0]]) begin
          node_nxt  = row_r[hfcs_pkg::ROW_W-1:0];
          state_nxt = hfcs_pkg::S_CHASE;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end
      hfcs_pkg::S_CHASE: begin
        if (par != node_r) begin
          node_nxt = par;
        end else if (seen_r[node_r]) begin
          // two rows share a root: column would close a cycle
          state_nxt = hfcs_pkg::S_NEXT;
        end else begin
          seen_nxt[node_r] = 1'b1;
          if (!hb_r || rk > brank_r) begin
            hb_nxt    = 1'b1;
            brank_nxt = rk;
            broot_nxt = node_r;
            tie_nxt   = 1'b0;
          end else if (rk == brank_r) begin
            tie_nxt = 1'b1;
          end
          row_nxt   = row_r + 1'b1;
          state_nxt = hfcs_pkg::S_ROW;
        end
      end
      hfcs_pkg::S_COMMIT: begin
        for (int i = 0; i < hfcs_pkg::MAX_ROWS; i++) begin
          if (seen_r[i]) begin
            parent_nxt[i] = broot_r;
          end
        end
        if (tie_r && rank_r[broot_r] < hfcs_pkg::RANK_MAX) begin
          rank_nxt[broot_r] = rank_r[broot_r] + 1'b1;
        end
        // hold back one pick so the final one can carry the last flag
        if (pend_vld_r) begin
          ostb_nxt  = 1'b1;
          oidx_nxt  = pend_r;
          ohas_nxt  = 1'b1;
          olast_nxt = 1'b0;
        end
        pend_vld_nxt = 1'b1;
        pend_nxt     = best_key_r[hfcs_pkg::COL_W-1:0];
        state_nxt    = hfcs_pkg::S_NEXT;
      end
      hfcs_pkg::S_NEXT: begin
        picks_nxt    = picks_r + 1'b1;
        prev_vld_nxt = 1'b1;
        prev_key_nxt = best_key_r;
        best_vld_nxt = 1'b0;
        scan_nxt     = '0;
        if (picks_r + 1'b1 == loaded_r) begin
          state_nxt = hfcs_pkg::S_FLUSH;
        end else begin
          state_nxt = hfcs_pkg::S_SEL;
        end
      end
      hfcs_pkg::S_FLUSH: begin
        ostb_nxt   = 1'b1;
        oidx_nxt   = pend_vld_r ? pend_r : '0;
        ohas_nxt   = pend_vld_r;
        olast_nxt  = 1'b1;
        loaded_nxt = '0;
        for (int i = 0; i < hfcs_pkg::MAX_ROWS; i++) begin
          parent_nxt[i] = hfcs_pkg::ROW_W'(i);
          rank_nxt[i]   = '0;
        end
        state_nxt = hfcs_pkg::S_IDLE;
      end
      default: begin
        state_nxt = hfcs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= hfcs_pkg::S_IDLE;
      rows_r     <= hfcs_pkg::ROWS_FULL;
      loaded_r   <= '0;
      scan_r     <= '0;
      picks_r    <= '0;
      cmp_vld_r  <= 1'b0;
      best_vld_r <= 1'b0;
      prev_vld_r <= 1'b0;
      pend_vld_r <= 1'b0;
      ostb_r     <= 1'b0;
      hb_r       <= 1'b0;
      tie_r      <= 1'b0;
      seen_r     <= '0;
      row_r      <= '0;
      for (int i = 0; i < hfcs_pkg::MAX_ROWS; i++) begin
        parent_r[i] <= hfcs_pkg::ROW_W'(i);
        rank_r[i]   <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      rows_r     <= rows_nxt;
      loaded_r   <= loaded_nxt;
      scan_r     <= scan_nxt;
      picks_r    <= picks_nxt;
      cmp_vld_r  <= (state_r == hfcs_pkg::S_SEL);
      best_vld_r <= best_vld_nxt;
      prev_vld_r <= prev_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      ostb_r     <= ostb_nxt;
      hb_r       <= hb_nxt;
      tie_r      <= tie_nxt;
      seen_r     <= seen_nxt;
      row_r      <= row_nxt;
      parent_r   <= parent_nxt;
      rank_r     <= rank_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    best_key_r  <= best_key_nxt;
    best_bits_r <= best_bits_nxt;
    prev_key_r  <= prev_key_nxt;
    node_r      <= node_nxt;
    brank_r     <= brank_nxt;
    broot_r     <= broot_nxt;
    pend_r      <= pend_nxt;
    oidx_r      <= oidx_nxt;
    ohas_r      <= ohas_nxt;
    olast_r     <= olast_nxt;
  end

  // column store
  always_ff @(posedge clk) begin
    if (load && loaded_r < hfcs_pkg::CNT_W'(hfcs_pkg::MAX_COLS)) begin
      col_mem[loaded_r[hfcs_pkg::COL_W-1:0]] <= in_column_rows;
      rel_mem[loaded_r[hfcs_pkg::COL_W-1:0]] <= in_reliability;
    end
    cmp_bits_r <= col_mem[scan_r[hfcs_pkg::COL_W-1:0]];
    cmp_rel_r  <= rel_mem[scan_r[hfcs_pkg::COL_W-1:0]];
    cmp_idx_r  <= scan_r[hfcs_pkg::COL_W-1:0];
  end

  `HFCS_AST_NOW(a_last_ends_run, out_strobe && out_last_pick, !busy)
  `HFCS_AST_NOW(a_empty_is_last, out_strobe && !out_has_pick, out_last_pick)
  `HFCS_AST_NXT(a_last_col_runs, start && !busy && in_last_column, busy)
  `HFCS_AST_NOW(a_no_pulse_idle, out_strobe && out_last_pick, $past(busy))

endmodule

// ===== dv/hypergraph_forest_column_select_top_test.sv =====
// self-checking testbench for the spanning forest column selector
module hypergraph_forest_column_select_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0]       rows;
    logic signed [15:0] rel;
    logic              last;
  } column_t;

  typedef struct {
    logic [hfcs_pkg::COL_W-1:0] index;
    logic             has_pick;
    logic             last_pick;
  } pick_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [31:0] in_column_rows = '0;
  logic signed [hfcs_pkg::REL_W-1:0] in_reliability = '0;
  logic in_last_column = 1'b0;
  logic out_strobe;
  logic [hfcs_pkg::COL_W-1:0] out_column_index;
  logic out_has_pick, out_last_pick;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [hfcs_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  hypergraph_forest_column_select_top dut (.*);

  initial forever #1 clk = ~clk;

  column_t pending_columns[$];
  pick_t   picks_due[$];
  int      idle_pct = 0;
  bit      took = 1'b0;
  int      errors = 0, runs_done = 0, columns_sent = 0, picks_seen = 0;

  // forest model state
  logic [31:0]        col_mem[hfcs_pkg::MAX_COLS];
  logic signed [15:0] rel_mem[hfcs_pkg::MAX_COLS];
  int                 n_loaded = 0;
  logic [5:0]         rows_reg = hfcs_pkg::ROWS_FULL;
  int                 parent[hfcs_pkg::MAX_ROWS];
  int                 rank[hfcs_pkg::MAX_ROWS];

  function automatic int root_of(int r);
    int p;
    for (int n = 0; n < hfcs_pkg::MAX_ROWS; n++) begin
      p = parent[r];
      if (p == r) break;
      r = p;
    end
    return r;
  endfunction

  task automatic load_and_select(column_t c);
    int   order[hfcs_pkg::MAX_COLS];
    bit   used[hfcs_pkg::MAX_COLS];
    bit   seen[hfcs_pkg::MAX_ROWS];
    int   rows, best, best_root, best_rank, rt, emitted;
    bit   ok, tie;
    pick_t p;
    if (n_loaded < hfcs_pkg::MAX_COLS) begin
      col_mem[n_loaded] = c.rows;
      rel_mem[n_loaded] = c.rel;
      n_loaded++;
    end
    if (!c.last) return;
    rows = rows_reg;
    if (rows < 1) rows = 1;
    if (rows > hfcs_pkg::MAX_ROWS) rows = hfcs_pkg::MAX_ROWS;
    // ascending reliability, lower load index wins a tie
    for (int i = 0; i < n_loaded; i++) used[i] = 0;
    for (int i = 0; i < n_loaded; i++) begin
      best = -1;
      for (int j = 0; j < n_loaded; j++)
        if (!used[j] && (best < 0 || rel_mem[j] < rel_mem[best])) best = j;
      used[best] = 1;
      order[i] = best;
    end
    for (int r = 0; r < hfcs_pkg::MAX_ROWS; r++) begin
      parent[r] = r;
      rank[r] = 0;
    end
    emitted = 0;
    for (int i = 0; i < n_loaded; i++) begin
      ok = 1;
      tie = 0;
      best_root = 0;
      best_rank = -1;
      for (int r = 0; r < hfcs_pkg::MAX_ROWS; r++) seen[r] = 0;
      for (int r = 0; r < rows; r++) begin
        if (col_mem[order[i]][r]) begin
          rt = root_of(r);
          if (seen[rt]) begin
            ok = 0;
            break;
          end
          seen[rt] = 1;
          if (rank[rt] > best_rank) begin
            best_rank = rank[rt];
            best_root = rt;
            tie = 0;
          end else if (rank[rt] == best_rank) begin
            tie = 1;
          end
        end
      end
      if (ok) begin
        for (int r = 0; r < hfcs_pkg::MAX_ROWS; r++)
          if (seen[r]) parent[r] = best_root;
        if (tie && rank[best_root] < 7) rank[best_root]++;
        p.index = hfcs_pkg::COL_W'(order[i]);
        p.has_pick = 1'b1;
        p.last_pick = 1'b0;
        picks_due.insert(picks_due.size(), p);
        emitted++;
      end
    end
    if (emitted == 0) begin
      p.index = '0;
      p.has_pick = 1'b0;
      p.last_pick = 1'b1;
      picks_due.insert(picks_due.size(), p);
    end else begin
      picks_due[picks_due.size()-1].last_pick = 1'b1;
    end
    n_loaded = 0;
    runs_done++;
  endtask

  // driver: holds an item until it is taken
  always @(negedge clk) begin
    column_t c;
    if (start && !took) begin
    end else if (pending_columns.size() > 0 && $urandom_range(99) >= idle_pct) begin
      c = pending_columns.pop_front();
      start <= 1'b1;
      in_column_rows <= c.rows;
      in_reliability <= c.rel;
      in_last_column <= c.last;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    column_t c;
    pick_t   e;
    took <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      c.rows = in_column_rows;
      c.rel = in_reliability;
      c.last = in_last_column;
      columns_sent++;
      load_and_select(c);
    end
    if (rst_n && out_strobe) begin
      picks_seen++;
      if (picks_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected pick index %0d has %0b last %0b", $time,
                 out_column_index, out_has_pick, out_last_pick);
      end else begin
        e = picks_due.pop_front();
        if (out_column_index !== e.index) begin
          errors++;
          $display("%0t: column_index exp %0d got %0d", $time, e.index, out_column_index);
        end
        if (out_has_pick !== e.has_pick) begin
          errors++;
          $display("%0t: has_pick exp %0b got %0b", $time, e.has_pick, out_has_pick);
        end
        if (out_last_pick !== e.last_pick) begin
          errors++;
          $display("%0t: last_pick exp %0b got %0b", $time, e.last_pick, out_last_pick);
        end
      end
    end
  end

  task automatic write_rows(logic [5:0] v);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= '0;
    cfg_pwdata <= {26'd0, v};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    rows_reg = v;
  endtask

  function automatic logic [31:0] random_rows();
    logic [31:0] v;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = '0;
      2: v = 32'd1 << $urandom_range(31);
      3: v = (32'd1 << $urandom_range(31)) | (32'd1 << $urandom_range(31))
             | (32'd1 << $urandom_range(31));
      4: v = $urandom & $urandom & $urandom;
      default: v = (32'd1 << $urandom_range(7)) | (32'd1 << $urandom_range(7));
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] random_rel();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(3));  // ties
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom_range(255) - 128);
    endcase
  endfunction

  task automatic push_column(logic [31:0] rows, logic signed [15:0] rel, logic last);
    column_t c;
    c.rows = rows;
    c.rel = rel;
    c.last = last;
    pending_columns.insert(pending_columns.size(), c);
  endtask

  task automatic push_run(int n);
    for (int i = 0; i < n; i++) push_column(random_rows(), random_rel(), i == n - 1);
  endtask

  task automatic drain();
    wait (pending_columns.size() == 0 && !start && picks_due.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [5:0] rows_cfg[6] = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd5, 6'd32};
    int pct[6] = '{0, 64, 8, 0, 64, 8};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: extremes of fields, ties, empty column, single column run
    push_column(32'h0, 16'sh0, 1'b1);
    push_column(32'hffff_ffff, 16'sh8000, 1'b0);
    push_column(32'h8000_0000, 16'sh7fff, 1'b0);
    push_column(32'h0000_0001, 16'sh0000, 1'b0);
    push_column(32'h0000_0003, 16'sh0000, 1'b0);
    push_column(32'h0000_0006, 16'sh0000, 1'b0);
    push_column(32'h0000_0005, 16'shff80, 1'b0);
    push_column(32'h8000_0001, 16'sh7fff, 1'b1);
    // tree of pairwise unions to drive ranks up
    for (int i = 0; i < 16; i++)
      push_column(32'd3 << (2 * i), 16'sh0100, 1'b0);
    for (int i = 0; i < 8; i++)
      push_column(32'd5 << (4 * i), 16'sh0200, i == 7);
    drain();

    // store overflow: columns beyond the store are dropped
    push_run(70);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = pct[ph];
      write_rows(rows_cfg[ph]);
      while (pending_columns.size() < 35) push_run($urandom_range(1, 12));
      if (ph == 2) push_run(hfcs_pkg::MAX_COLS);
      drain();
    end

    $display("ran %0d runs from %0d columns, checked %0d picks", runs_done,
             columns_sent, picks_seen);
    $display("row counts 0, 1, 5, 32, 63 with idle sender phases");
    if (errors == 0)
      $display("hypergraph_forest_column_select_top regression: pass");
    else
      $display("hypergraph_forest_column_select_top regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("hypergraph_forest_column_select_top regression: fail");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hfcs_pkg.sv
rtl/hypergraph_forest_column_select_top.sv
dv/hypergraph_forest_column_select_top_test.sv
